// ===== sv/tne_pkg.sv =====
// Shared types, register codes and constants of the torus neighbor enumerator.
package tne_pkg;

   // Fixed widths of the register file and the result fields
   localparam int NUM_SIZES    = 5;
   localparam int ID_BITS      = 30;
   localparam int POS_BITS     = 4;
   localparam int DIMS_BITS    = 3;
   localparam int SIZE_BITS    = 7;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [DIMS_BITS-1:0] DIMS_RESET = 3'd5;
   localparam logic [NUM_SIZES-1:0][SIZE_BITS-1:0] SIZE_RESET =
      {7'd2, 7'd4, 7'd4, 7'd4, 7'd4};

   // Register indexes on the csr channel
   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_DIMS   = 3'd0,
      REG_SIZE_0 = 3'd1,
      REG_SIZE_1 = 3'd2,
      REG_SIZE_2 = 3'd3,
      REG_SIZE_3 = 3'd4,
      REG_SIZE_4 = 3'd5
   } csr_reg_type;

   // Candidate moves: {pass, half}; mesh pass first, then wrap pass
   typedef enum logic [1:0] {
      MOVE_DOWN    = 2'd0,
      MOVE_UP      = 2'd1,
      MOVE_WRAP_LO = 2'd2,
      MOVE_WRAP_HI = 2'd3
   } move_type;

   // Live register contents
   typedef struct packed {
      logic [DIMS_BITS-1:0]                  dims_in_use;
      logic [NUM_SIZES-1:0][SIZE_BITS-1:0]   size;
   } cfg_type;

   // Width of one queued job: base id, strides, coords, size-1, move flags, count, bad flag
   function automatic int job_bits(input int dims, input int coord_bits);
      return ID_BITS * (dims + 1) + 2 * dims * coord_bits + 4 * dims + $clog2(dims + 1) + 1;
   endfunction

endpackage

// ===== sv/tne_ifs.sv =====
// Channel interfaces: coordinate requests, neighbor results and register writes.
interface tne_req_if #(parameter int COORD_BITS = 6);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] coord_0;
   logic [COORD_BITS-1:0] coord_1;
   logic [COORD_BITS-1:0] coord_2;
   logic [COORD_BITS-1:0] coord_3;
   logic [COORD_BITS-1:0] coord_4;
   modport source (output valid, coord_0, coord_1, coord_2, coord_3, coord_4, input ready);
   modport sink   (input valid, coord_0, coord_1, coord_2, coord_3, coord_4, output ready);
endinterface

interface tne_rsp_if import tne_pkg::*;;
   logic                valid;
   logic                ready;
   logic [ID_BITS-1:0]  neighbor_id;
   logic [POS_BITS-1:0] position;
   logic                last;
   logic                empty_res;
   logic                bad_coord;
   modport source (output valid, neighbor_id, position, last, empty_res, bad_coord,
                   input ready);
   modport sink   (input valid, neighbor_id, position, last, empty_res, bad_coord,
                   output ready);
endinterface

interface tne_csr_if import tne_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [SIZE_BITS-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/tne_csr.sv =====
// Configuration register file: dimension count and per-dimension extents.
module tne_csr import tne_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   tne_csr_if.sink csr,
   output cfg_type cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr_reg_type'(csr.index))
            REG_DIMS:   cfg_in.dims_in_use = csr.data[DIMS_BITS-1:0];
            REG_SIZE_0: cfg_in.size[0] = csr.data;
            REG_SIZE_1: cfg_in.size[1] = csr.data;
            REG_SIZE_2: cfg_in.size[2] = csr.data;
            REG_SIZE_3: cfg_in.size[3] = csr.data;
            REG_SIZE_4: cfg_in.size[4] = csr.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dims_in_use <= DIMS_RESET;
         cfg_ff.size        <= SIZE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/tne_front.sv =====
// Front end: takes a request, checks coordinates, builds base id and strides.
module tne_front import tne_pkg::*; #(
   parameter int DIM_LIM    = 5,
   parameter int COORD_BITS = 6
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   tne_req_if.sink req,
   output logic    push_valid,
   input  logic    push_ready,
   output logic [job_bits(DIM_LIM, COORD_BITS)-1:0] push_data
);

   localparam int EffBits = COORD_BITS + 1;
   localparam int NdBits  = $clog2(DIM_LIM + 1);
   localparam int JBits   = (DIM_LIM > 1) ? $clog2(DIM_LIM) : 1;
   localparam int Cap     = 1 << COORD_BITS;

   typedef struct packed {
      logic [ID_BITS-1:0]                     base;
      logic [DIM_LIM-1:0][ID_BITS-1:0]        stride;
      logic [DIM_LIM-1:0][COORD_BITS-1:0]     coord;
      logic [DIM_LIM-1:0][COORD_BITS-1:0]     size_m1;
      logic [DIM_LIM-1:0][3:0]                moves;
      logic [NdBits-1:0]                      nd;
      logic                                   bad;
   } job_type;

   typedef enum logic [1:0] {F_IDLE, F_RUN, F_PUSH} front_state_type;

   front_state_type           state_ff, state_in;
   logic [JBits-1:0]          j_ff, j_in;
   logic [ID_BITS-1:0]        acc_ff, acc_in;
   logic [ID_BITS-1:0]        base_ff, base_in;
   logic [ID_BITS-1:0]        stride_ff [DIM_LIM];
   logic [ID_BITS-1:0]        stride_in [DIM_LIM];
   logic [COORD_BITS-1:0]     coord_ff  [DIM_LIM];
   logic [COORD_BITS-1:0]     coord_in  [DIM_LIM];
   logic [EffBits-1:0]        size_ff   [DIM_LIM];
   logic [EffBits-1:0]        size_in   [DIM_LIM];
   logic [NdBits-1:0]         nd_ff, nd_in;

   logic [COORD_BITS-1:0]     req_coord [NUM_SIZES];
   logic [EffBits-1:0]        eff_size  [DIM_LIM];
   logic [NdBits-1:0]         nd_clamp;
   logic [ID_BITS+EffBits-1:0]    acc_prod;
   logic [ID_BITS+COORD_BITS-1:0] coord_prod;
   job_type                   job;

   assign req_coord[0] = req.coord_0;
   assign req_coord[1] = req.coord_1;
   assign req_coord[2] = req.coord_2;
   assign req_coord[3] = req.coord_3;
   assign req_coord[4] = req.coord_4;

   // Clamp dimension count and extents
   always_comb begin
      if (cfg.dims_in_use == '0) begin
         nd_clamp = NdBits'(1);
      end else if (int'(cfg.dims_in_use) > DIM_LIM) begin
         nd_clamp = NdBits'(DIM_LIM);
      end else begin
         nd_clamp = NdBits'(cfg.dims_in_use);
      end
      for (int i = 0; i < DIM_LIM; i++) begin
         if (int'(cfg.size[i]) > Cap) begin
            eff_size[i] = EffBits'(Cap);
         end else begin
            eff_size[i] = EffBits'(cfg.size[i]);
         end
      end
   end

   // One dimension per cycle, last dimension first:
   // stride[j] = acc, acc *= size[j], base += coord[j] * stride[j]
   assign acc_prod   = acc_ff * size_ff[j_ff];
   assign coord_prod = coord_ff[j_ff] * acc_ff;

   // Job word seen by the back end
   always_comb begin
      job.base = base_ff;
      job.nd   = nd_ff;
      job.bad  = 1'b0;
      for (int i = 0; i < DIM_LIM; i++) begin
         job.stride[i]                = stride_ff[i];
         job.coord[i]                 = coord_ff[i];
         job.size_m1[i]               = COORD_BITS'(size_ff[i] - EffBits'(1));
         job.moves[i][MOVE_DOWN]      = (coord_ff[i] != '0);
         job.moves[i][MOVE_UP]        = (EffBits'(coord_ff[i]) + EffBits'(1)) < size_ff[i];
         job.moves[i][MOVE_WRAP_LO]   = (coord_ff[i] == '0);
         job.moves[i][MOVE_WRAP_HI]   = EffBits'(coord_ff[i]) == (size_ff[i] - EffBits'(1));
         if ((NdBits'(i) < nd_ff) && (EffBits'(coord_ff[i]) >= size_ff[i])) begin
            job.bad = 1'b1;
         end
      end
   end

   assign req.ready  = (state_ff == F_IDLE);
   assign push_valid = (state_ff == F_PUSH);
   assign push_data  = job;

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      j_in      = j_ff;
      acc_in    = acc_ff;
      base_in   = base_ff;
      stride_in = stride_ff;
      coord_in  = coord_ff;
      size_in   = size_ff;
      nd_in     = nd_ff;
      case (state_ff)
         F_IDLE: begin
            if (req.valid) begin
               for (int i = 0; i < DIM_LIM; i++) begin
                  coord_in[i] = req_coord[i];
                  size_in[i]  = eff_size[i];
               end
               nd_in    = nd_clamp;
               j_in     = JBits'(nd_clamp - NdBits'(1));
               acc_in   = ID_BITS'(1);
               base_in  = '0;
               state_in = F_RUN;
            end
         end
         F_RUN: begin
            stride_in[j_ff] = acc_ff;
            acc_in          = acc_prod[ID_BITS-1:0];
            base_in         = base_ff + coord_prod[ID_BITS-1:0];
            if (j_ff == '0) begin
               state_in = F_PUSH;
            end else begin
               j_in = j_ff - JBits'(1);
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      j_ff      <= j_in;
      acc_ff    <= acc_in;
      base_ff   <= base_in;
      stride_ff <= stride_in;
      coord_ff  <= coord_in;
      size_ff   <= size_in;
      nd_ff     <= nd_in;
   end

endmodule

// ===== sv/tne_queue.sv =====
// Two-entry job queue between front end and back end.
module tne_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int Depth = 2;

   logic [WIDTH-1:0] entry_ff [Depth];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != 2'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_in    = do_push ? ~wr_ff : wr_ff;
      rd_in    = do_pop ? ~rd_ff : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   // Fill level never passes the depth
   assert property (@(posedge clock) disable iff (reset) count_ff <= 2'(Depth))
      else $error("tne_queue: fill level above depth");

endmodule

// ===== sv/tne_back.sv =====
// Back end: walks the candidate moves, dedups ids, and streams the results.
module tne_back import tne_pkg::*; #(
   parameter int DIM_LIM    = 5,
   parameter int COORD_BITS = 6,
   parameter int MAX_RES    = 10
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  logic [job_bits(DIM_LIM, COORD_BITS)-1:0] pop_data,
   tne_rsp_if.source rsp
);

   localparam int NdBits  = $clog2(DIM_LIM + 1);
   localparam int JBits   = (DIM_LIM > 1) ? $clog2(DIM_LIM) : 1;
   localparam int CntBits = $clog2(MAX_RES + 1);
   localparam int EBits   = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;

   typedef struct packed {
      logic [ID_BITS-1:0]                     base;
      logic [DIM_LIM-1:0][ID_BITS-1:0]        stride;
      logic [DIM_LIM-1:0][COORD_BITS-1:0]     coord;
      logic [DIM_LIM-1:0][COORD_BITS-1:0]     size_m1;
      logic [DIM_LIM-1:0][3:0]                moves;
      logic [NdBits-1:0]                      nd;
      logic                                   bad;
   } job_type;

   typedef enum logic [1:0] {B_IDLE, B_ENUM, B_DRAIN, B_EMIT} back_state_type;

   back_state_type        state_ff, state_in;
   job_type               job_ff, job_in;
   logic                  pass_ff, pass_in;
   logic                  half_ff, half_in;
   logic [JBits-1:0]      d_ff, d_in;
   logic [EBits-1:0]      e_ff, e_in;
   logic [CntBits-1:0]    cnt_ff, cnt_in;
   logic [ID_BITS-1:0]    found_ff [MAX_RES];
   logic [ID_BITS-1:0]    found_in [MAX_RES];
   logic                  p_valid_ff, p_valid_in;
   logic                  p_sub_ff, p_sub_in;
   logic [ID_BITS-1:0]    p_prod_ff, p_prod_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ID_BITS-1:0]    rsp_id_ff, rsp_id_in;
   logic [POS_BITS-1:0]   rsp_pos_ff, rsp_pos_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic                  rsp_bad_ff, rsp_bad_in;

   move_type                      move;
   logic                          exists;
   logic [COORD_BITS-1:0]         mult;
   logic [ID_BITS+COORD_BITS-1:0] prod_full;
   logic [ID_BITS-1:0]            cand_id;
   logic                          hit;
   logic                          last_dim;
   logic                          out_free;
   logic                          e_last;

   // Stage A: candidate offset = stride * {1, size-1, coord}
   assign move     = move_type'({pass_ff, half_ff});
   assign exists   = job_ff.moves[d_ff][move];
   assign last_dim = (d_ff == JBits'(job_ff.nd - NdBits'(1)));

   always_comb begin
      case (move)
         MOVE_WRAP_LO: mult = job_ff.size_m1[d_ff];
         MOVE_WRAP_HI: mult = job_ff.coord[d_ff];
         default:      mult = COORD_BITS'(1);
      endcase
   end

   assign prod_full = job_ff.stride[d_ff] * mult;

   // Stage B: candidate id and compare against the found list
   assign cand_id = p_sub_ff ? (job_ff.base - p_prod_ff) : (job_ff.base + p_prod_ff);

   always_comb begin
      hit = 1'b0;
      for (int j = 0; j < MAX_RES; j++) begin
         if ((CntBits'(j) < cnt_ff) && (found_ff[j] == cand_id)) begin
            hit = 1'b1;
         end
      end
   end

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign e_last    = (CntBits'(e_ff) + CntBits'(1)) == cnt_ff;
   assign pop_ready = (state_ff == B_IDLE);

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      pass_in      = pass_ff;
      half_in      = half_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      p_valid_in   = 1'b0;
      p_sub_in     = (move == MOVE_DOWN) || (move == MOVE_WRAP_HI);
      p_prod_in    = prod_full[ID_BITS-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_id_in    = rsp_id_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_bad_in   = rsp_bad_ff;

      // Insert a new id
      if (p_valid_ff && !hit && (cnt_ff < CntBits'(MAX_RES))) begin
         found_in[cnt_ff[EBits-1:0]] = cand_id;
         cnt_in = cnt_ff + CntBits'(1);
      end

      case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               job_in   = job_type'(pop_data);
               pass_in  = 1'b0;
               half_in  = 1'b0;
               d_in     = '0;
               e_in     = '0;
               cnt_in   = '0;
               state_in = job_in.bad ? B_EMIT : B_ENUM;
            end
         end
         B_ENUM: begin
            // Mesh pass over all used dimensions, then wrap pass
            p_valid_in = exists;
            half_in    = ~half_ff;
            if (half_ff) begin
               if (last_dim) begin
                  d_in    = '0;
                  pass_in = 1'b1;
                  if (pass_ff) begin
                     state_in = B_DRAIN;
                  end
               end else begin
                  d_in = d_ff + JBits'(1);
               end
            end
         end
         B_DRAIN: begin
            state_in = B_EMIT;
         end
         B_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (job_ff.bad) begin
                  rsp_id_in    = '0;
                  rsp_pos_in   = '0;
                  rsp_last_in  = 1'b1;
                  rsp_empty_in = 1'b0;
                  rsp_bad_in   = 1'b1;
                  state_in     = B_IDLE;
               end else if (cnt_ff == '0) begin
                  rsp_id_in    = '0;
                  rsp_pos_in   = '0;
                  rsp_last_in  = 1'b1;
                  rsp_empty_in = 1'b1;
                  rsp_bad_in   = 1'b0;
                  state_in     = B_IDLE;
               end else begin
                  rsp_id_in    = found_ff[e_ff];
                  rsp_pos_in   = POS_BITS'(e_ff);
                  rsp_last_in  = e_last;
                  rsp_empty_in = 1'b0;
                  rsp_bad_in   = 1'b0;
                  if (e_last) begin
                     state_in = B_IDLE;
                  end else begin
                     e_in = e_ff + EBits'(1);
                  end
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         cnt_ff       <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff       <= job_in;
      pass_ff      <= pass_in;
      half_ff      <= half_in;
      d_ff         <= d_in;
      e_ff         <= e_in;
      found_ff     <= found_in;
      p_sub_ff     <= p_sub_in;
      p_prod_ff    <= p_prod_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.neighbor_id = rsp_id_ff;
   assign rsp.position    = rsp_pos_ff;
   assign rsp.last        = rsp_last_ff;
   assign rsp.empty_res   = rsp_empty_ff;
   assign rsp.bad_coord   = rsp_bad_ff;

   // Found list never overflows
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= CntBits'(MAX_RES))
      else $error("tne_back: found count above capacity");

   // Compare stage only runs while walking candidates or draining
   assert property (@(posedge clock) disable iff (reset)
      p_valid_ff |-> (state_ff == B_ENUM || state_ff == B_DRAIN))
      else $error("tne_back: compare stage active outside enumeration");

   // Error and empty results are single, final and exclusive
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_bad_ff || rsp_empty_ff) |-> rsp_last_ff && !(rsp_bad_ff && rsp_empty_ff))
      else $error("tne_back: malformed error or empty result");

endmodule

// ===== sv/torus_neighbor_enumerator_top.sv =====
// Top level of the torus neighbor enumerator: registers, front end, job queue, back end.
//
//   channel  dir  handshake          payload
//   req_ch   in   valid/ready        coord_0 .. coord_4
//   rsp_ch   out  valid/ready        neighbor_id, position, last, empty_res, bad_coord
//   csr_ch   in   valid/ready (=1)   index (0 dims_in_use, 1..5 size_0..size_4), data
//
// Front end: one multiply-accumulate step per used dimension for each request, then a push.
// Back end: walks the candidate moves one candidate per cycle, then streams the results,
// each held while rsp_ch is not ready; the back-end candidate walk sets the sustained rate.
// A two-entry queue lets the front take the next request while results drain.
// Reset is synchronous; rsp_ch holds its result in a register while ready is low.
module torus_neighbor_enumerator_top import tne_pkg::*; #(
   parameter int MAX_DIMS   = 5,
   parameter int COORD_BITS = 6
) (
   input  logic      clock,
   input  logic      reset,
   tne_csr_if.sink   csr_ch,
   tne_req_if.sink   req_ch,
   tne_rsp_if.source rsp_ch
);

   localparam int DimLim  = (MAX_DIMS < NUM_SIZES) ? MAX_DIMS : NUM_SIZES;
   localparam int MaxRes  = 2 * MAX_DIMS;
   localparam int JobBits = job_bits(DimLim, COORD_BITS);

   cfg_type              cfg;
   logic                 push_valid;
   logic                 push_ready;
   logic [JobBits-1:0]   push_data;
   logic                 pop_valid;
   logic                 pop_ready;
   logic [JobBits-1:0]   pop_data;

   tne_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ch),
      .cfg   (cfg)
   );

   tne_front #(
      .DIM_LIM    (DimLim),
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req        (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   tne_queue #(
      .WIDTH (JobBits)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   tne_back #(
      .DIM_LIM    (DimLim),
      .COORD_BITS (COORD_BITS),
      .MAX_RES    (MaxRes)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp_ch)
   );

endmodule
